// ===== rtl/aarm_pkg.sv =====
// Shared types, widths and fixed-point constants for the axis-angle rotation matrix core.
// Used by aarm_cordic, axis_angle_rotation_matrix_core, rot_matrix_checker and tb_top. No dependencies.
package aarm_pkg;

  // Precision knobs
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 15;

  // Port formats
  localparam int ANG_W     = 19;
  localparam int ANG_FRAC  = 15;
  localparam int AXIS_W    = 16;
  localparam int AXIS_FRAC = 15;
  localparam int OUT_W     = 16;
  localparam int OUT_FRAC  = 15;

  // Internal widths
  localparam int Z_W    = FRAC_BITS + 6;   // angle after wrap, plus headroom
  localparam int XY_W   = FRAC_BITS + 3;   // CORDIC x/y, sine, cosine
  localparam int T_W    = FRAC_BITS + 4;   // t = 1 - cos
  localparam int PROD_W = 2 * AXIS_W;      // a_i * a_j, Q2.30
  localparam int ACC_W  = T_W + PROD_W;    // entry sum before rounding

  // Q30 constants
  localparam logic [63:0] Q30_PI      = 64'd3373259426;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
  localparam logic [63:0] Q30_GAIN    = 64'd652032874;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_AXIS_X = 2'd0,
    CFG_AXIS_Y = 2'd1,
    CFG_AXIS_Z = 2'd2
  } cfg_reg_t;

  // Sine/cosine item leaving the CORDIC
  typedef struct packed {
    logic                   valid;
    logic signed [XY_W-1:0] cos_val;
    logic signed [XY_W-1:0] sin_val;
  } sc_t;

  // Round a positive Q30 constant half up to FRAC_BITS
  function automatic logic [63:0] from_q30(input logic [63:0] v);
    logic [63:0] r;
    if (FRAC_BITS >= 30) begin
      r = v;
    end else begin
      r = (v + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    end
    return r;
  endfunction

  // Arctangent of 2^-i in Q30
  function automatic logic [63:0] atan_q30(input int i);
    logic [63:0] r;
    case (i)
      0:       r = 64'h3243F6A8;
      1:       r = 64'h1DAC6705;
      2:       r = 64'h0FADBAFC;
      3:       r = 64'h07F56EA6;
      4:       r = 64'h03FEAB76;
      5:       r = 64'h01FFD55B;
      6:       r = 64'h00FFFAAA;
      7:       r = 64'h007FFF55;
      8:       r = 64'h003FFFEA;
      9:       r = 64'h001FFFFD;
      10:      r = 64'h000FFFFF;
      11:      r = 64'h0007FFFF;
      12:      r = 64'h0003FFFF;
      13:      r = 64'h0001FFFF;
      14:      r = 64'h0000FFFF;
      15:      r = 64'h00007FFF;
      16:      r = 64'h00003FFF;
      17:      r = 64'h00001FFF;
      18:      r = 64'h00000FFF;
      19:      r = 64'h000007FF;
      20:      r = 64'h000003FF;
      21:      r = 64'h000001FF;
      22:      r = 64'h000000FF;
      23:      r = 64'h0000007F;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/aarm_cordic.sv =====
// Pipelined sine/cosine: angle capture, 2*pi wrap, pi fold, one CORDIC stage per register, sign fix.
// Depends on aarm_pkg.
module aarm_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [aarm_pkg::ANG_W-1:0] in_angle,
  output aarm_pkg::sc_t                     sc
);

  localparam int N    = aarm_pkg::CORDIC_STAGES;
  localparam int Z_W  = aarm_pkg::Z_W;
  localparam int XY_W = aarm_pkg::XY_W;

  localparam logic signed [Z_W-1:0] PI_Z =
    Z_W'(aarm_pkg::from_q30(aarm_pkg::Q30_PI));
  localparam logic signed [Z_W-1:0] HALF_PI_Z =
    Z_W'(aarm_pkg::from_q30(aarm_pkg::Q30_HALF_PI));
  localparam logic signed [Z_W-1:0] TWO_PI_Z =
    Z_W'(aarm_pkg::from_q30(aarm_pkg::Q30_TWO_PI));
  localparam logic signed [XY_W-1:0] GAIN_XY =
    XY_W'(aarm_pkg::from_q30(aarm_pkg::Q30_GAIN));

  logic                              ang_v_r;
  logic signed [aarm_pkg::ANG_W-1:0] ang_r;
  logic signed [Z_W-1:0]             z_in;
  logic signed [Z_W-1:0]             zw_nxt;
  logic                              zw_v_r;
  logic signed [Z_W-1:0]             zw_r;
  logic signed [Z_W-1:0]             zf_nxt;
  logic                              negf_nxt;

  logic [N:0]             vld_r;
  logic [N:0]             neg_r;
  logic signed [XY_W-1:0] x_r [0:N];
  logic signed [XY_W-1:0] y_r [0:N];
  logic signed [Z_W-1:0]  z_r [0:N-1];

  aarm_pkg::sc_t sc_r;

  // Capture the angle
  always_ff @(posedge clk) begin
    ang_r <= in_angle;
  end

  // Bring the angle to the internal fraction width
  if (aarm_pkg::FRAC_BITS >= aarm_pkg::ANG_FRAC) begin : g_up
    assign z_in = Z_W'(ang_r) <<< (aarm_pkg::FRAC_BITS - aarm_pkg::ANG_FRAC);
  end else begin : g_dn
    assign z_in = Z_W'(ang_r >>> (aarm_pkg::ANG_FRAC - aarm_pkg::FRAC_BITS));
  end

  // Wrap once by 2*pi
  always_comb begin
    if (z_in > PI_Z) begin
      zw_nxt = z_in - TWO_PI_Z;
    end else if (z_in < -PI_Z) begin
      zw_nxt = z_in + TWO_PI_Z;
    end else begin
      zw_nxt = z_in;
    end
  end

  always_ff @(posedge clk) begin
    zw_r <= zw_nxt;
  end

  // Fold into [-pi/2, pi/2]; sine and cosine flip sign
  always_comb begin
    if (zw_r > HALF_PI_Z) begin
      zf_nxt   = zw_r - PI_Z;
      negf_nxt = 1'b1;
    end else if (zw_r < -HALF_PI_Z) begin
      zf_nxt   = zw_r + PI_Z;
      negf_nxt = 1'b1;
    end else begin
      zf_nxt   = zw_r;
      negf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= GAIN_XY;
    y_r[0]   <= '0;
    z_r[0]   <= zf_nxt;
    neg_r[0] <= negf_nxt;
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN_Z = Z_W'(aarm_pkg::from_q30(aarm_pkg::atan_q30(i)));
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;

    // x moves by the shifted y, y by the shifted x
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!z_r[i][Z_W-1]) begin
        x_r[i+1] <= x_r[i] - dx;
        y_r[i+1] <= y_r[i] + dy;
      end else begin
        x_r[i+1] <= x_r[i] + dx;
        y_r[i+1] <= y_r[i] - dy;
      end
      neg_r[i+1] <= neg_r[i];
    end

    if (i < N - 1) begin : g_z
      always_ff @(posedge clk) begin
        if (!z_r[i][Z_W-1]) begin
          z_r[i+1] <= z_r[i] - ATAN_Z;
        end else begin
          z_r[i+1] <= z_r[i] + ATAN_Z;
        end
      end
    end
  end

  // Undo the fold
  always_ff @(posedge clk) begin
    sc_r.cos_val <= neg_r[N] ? -x_r[N] : x_r[N];
    sc_r.sin_val <= neg_r[N] ? -y_r[N] : y_r[N];
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_v_r    <= 1'b0;
      zw_v_r     <= 1'b0;
      vld_r      <= '0;
      sc_r.valid <= 1'b0;
    end else begin
      ang_v_r    <= in_valid;
      zw_v_r     <= ang_v_r;
      vld_r      <= {vld_r[N-1:0], zw_v_r};
      sc_r.valid <= vld_r[N];
    end
  end

  assign sc = sc_r;

  // Wrapped angle stays within [-pi, pi]
  a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
    zw_v_r |-> (zw_r <= PI_Z) && (zw_r >= -PI_Z))
    else $error("wrapped angle out of range");

  // Folded angle stays within [-pi/2, pi/2]
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> (z_r[0] <= HALF_PI_Z) && (z_r[0] >= -HALF_PI_Z))
    else $error("folded angle out of range");

  // An item in the first rotation stage leaves after all stages
  a_stage_count: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(N + 1) sc_r.valid)
    else $error("item lost in rotation stages");

endmodule

// ===== rtl/axis_angle_rotation_matrix_core.sv =====
// Top level: axis registers, CORDIC sine/cosine and Rodrigues matrix pipeline.
// Depends on aarm_pkg and aarm_cordic.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ------------------------------
//  input    start, busy, in_angle                   taken when start && !busy
//  config   cfg_valid, cfg_ready, cfg_index, cfg_data  written when valid && ready
//  result   out_strobe, out_rot_r*_c*               one cycle, no back-pressure
//
// One item enters per clock; busy stays low and cfg_ready stays high.
// Registers from an accepted item to out_strobe: capture, wrap, fold, 16 rotation stages,
// sign fix, t, multiply, round.
// The depth is set by the CORDIC stage chain; the rest is a fixed tail of seven registers.
// Synchronous active-low reset clears valid bits and the axis registers (axis = 0).
// Nothing stalls: every stage advances every cycle.
module axis_angle_rotation_matrix_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [aarm_pkg::ANG_W-1:0]  in_angle,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [aarm_pkg::AXIS_W-1:0]        cfg_data,
  output logic                               out_strobe,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r0_c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r1_c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r2_c0,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r0_c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r1_c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r2_c1,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r0_c2,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r1_c2,
  output logic signed [aarm_pkg::OUT_W-1:0]  out_rot_r2_c2
);

  localparam int AXIS_W = aarm_pkg::AXIS_W;
  localparam int XY_W   = aarm_pkg::XY_W;
  localparam int T_W    = aarm_pkg::T_W;
  localparam int PROD_W = aarm_pkg::PROD_W;
  localparam int ACC_W  = aarm_pkg::ACC_W;
  localparam int OUT_W  = aarm_pkg::OUT_W;
  localparam int SH     = aarm_pkg::FRAC_BITS + aarm_pkg::OUT_FRAC;
  localparam int LAT    = aarm_pkg::CORDIC_STAGES + 7;

  localparam logic signed [T_W-1:0]   ONE_T   = T_W'(64'd1 << aarm_pkg::FRAC_BITS);
  localparam logic signed [ACC_W-1:0] RND     = ACC_W'(64'd1 << (SH - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

  // Round half up, drop fraction, clamp to the output range
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] q;
    r = a + RND;
    q = r >>> SH;
    if (q > OUT_MAX) begin
      q = OUT_MAX;
    end else if (q < OUT_MIN) begin
      q = OUT_MIN;
    end
    return OUT_W'(q);
  endfunction

  logic signed [AXIS_W-1:0] axis_x_r;
  logic signed [AXIS_W-1:0] axis_y_r;
  logic signed [AXIS_W-1:0] axis_z_r;
  logic signed [PROD_W-1:0] pxx_r, pyy_r, pzz_r, pxy_r, pxz_r, pyz_r;

  aarm_pkg::sc_t sc;

  logic                   v_t_r;
  logic signed [T_W-1:0]  t_r;
  logic signed [XY_W-1:0] c_r;
  logic signed [XY_W-1:0] s_r;

  logic signed [XY_W+AXIS_W-1:0] sx, sy, sz;
  logic                          v_m_r;
  logic signed [ACC_W-1:0]       mxx_r, myy_r, mzz_r, mxy_r, mxz_r, myz_r;
  logic signed [ACC_W-1:0]       cc_r, msx_r, msy_r, msz_r;

  logic                    strobe_r;
  logic signed [OUT_W-1:0] r00_r, r10_r, r20_r, r01_r, r11_r, r21_r, r02_r, r12_r, r22_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Axis registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_x_r <= '0;
      axis_y_r <= '0;
      axis_z_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (aarm_pkg::cfg_reg_t'(cfg_index))
        aarm_pkg::CFG_AXIS_X: axis_x_r <= cfg_data;
        aarm_pkg::CFG_AXIS_Y: axis_y_r <= cfg_data;
        aarm_pkg::CFG_AXIS_Z: axis_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold exact axis products, registered from the axis registers
  always_ff @(posedge clk) begin
    pxx_r <= axis_x_r * axis_x_r;
    pyy_r <= axis_y_r * axis_y_r;
    pzz_r <= axis_z_r * axis_z_r;
    pxy_r <= axis_x_r * axis_y_r;
    pxz_r <= axis_x_r * axis_z_r;
    pyz_r <= axis_y_r * axis_z_r;
  end

  aarm_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .in_angle (in_angle),
    .sc       (sc)
  );

  // Form t = 1 - cos
  always_ff @(posedge clk) begin
    t_r <= ONE_T - T_W'(sc.cos_val);
    c_r <= sc.cos_val;
    s_r <= sc.sin_val;
  end

  assign sx = s_r * axis_x_r;
  assign sy = s_r * axis_y_r;
  assign sz = s_r * axis_z_r;

  // Multiply terms, all aligned to FRAC_BITS + 30 fraction bits
  always_ff @(posedge clk) begin
    mxx_r <= t_r * pxx_r;
    myy_r <= t_r * pyy_r;
    mzz_r <= t_r * pzz_r;
    mxy_r <= t_r * pxy_r;
    mxz_r <= t_r * pxz_r;
    myz_r <= t_r * pyz_r;
    cc_r  <= ACC_W'(c_r) <<< (2 * aarm_pkg::AXIS_FRAC);
    msx_r <= ACC_W'(sx) <<< aarm_pkg::AXIS_FRAC;
    msy_r <= ACC_W'(sy) <<< aarm_pkg::AXIS_FRAC;
    msz_r <= ACC_W'(sz) <<< aarm_pkg::AXIS_FRAC;
  end

  // Sum, round and clamp each entry
  always_ff @(posedge clk) begin
    r00_r <= round_sat(mxx_r + cc_r);
    r10_r <= round_sat(mxy_r + msz_r);
    r20_r <= round_sat(mxz_r - msy_r);
    r01_r <= round_sat(mxy_r - msz_r);
    r11_r <= round_sat(myy_r + cc_r);
    r21_r <= round_sat(myz_r + msx_r);
    r02_r <= round_sat(mxz_r + msy_r);
    r12_r <= round_sat(myz_r - msx_r);
    r22_r <= round_sat(mzz_r + cc_r);
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_t_r    <= 1'b0;
      v_m_r    <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      v_t_r    <= sc.valid;
      v_m_r    <= v_t_r;
      strobe_r <= v_m_r;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_rot_r0_c0 = r00_r;
  assign out_rot_r1_c0 = r10_r;
  assign out_rot_r2_c0 = r20_r;
  assign out_rot_r0_c1 = r01_r;
  assign out_rot_r1_c1 = r11_r;
  assign out_rot_r2_c1 = r21_r;
  assign out_rot_r0_c2 = r02_r;
  assign out_rot_r1_c2 = r12_r;
  assign out_rot_r2_c2 = r22_r;

  // Every accepted item gives a strobe after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("result strobe missing after fixed latency");

  // Reset drops every item in flight
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe after reset");

  // A write to the x component lands in its register
  a_cfg_x: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == aarm_pkg::CFG_AXIS_X))
      |=> (axis_x_r == $signed($past(cfg_data))))
    else $error("axis x write lost");

endmodule

// ===== dv/rot_matrix_checker.sv =====
// Checker for the axis-angle rotation matrix core: tracks axis writes and angle items,
// predicts each 3x3 matrix and compares it with the result strobed out.
// Depends on aarm_pkg for widths, constants and register indexes.
module rot_matrix_checker
  import aarm_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [ANG_W-1:0]   in_angle,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [AXIS_W-1:0]         cfg_data,
  input  logic                      out_strobe,
  input  logic signed [OUT_W-1:0]   out_rot_r0_c0,
  input  logic signed [OUT_W-1:0]   out_rot_r1_c0,
  input  logic signed [OUT_W-1:0]   out_rot_r2_c0,
  input  logic signed [OUT_W-1:0]   out_rot_r0_c1,
  input  logic signed [OUT_W-1:0]   out_rot_r1_c1,
  input  logic signed [OUT_W-1:0]   out_rot_r2_c1,
  input  logic signed [OUT_W-1:0]   out_rot_r0_c2,
  input  logic signed [OUT_W-1:0]   out_rot_r1_c2,
  input  logic signed [OUT_W-1:0]   out_rot_r2_c2,
  output int                        mismatch_count,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Entry k sits at row k%3, column k/3 (column major)
  typedef logic [8:0][OUT_W-1:0] rot_mat_t;

  localparam int ATAN_LEN = 24;

  rot_mat_t expected_mats[$];
  rot_mat_t got;
  longint   axis_x_q;
  longint   axis_y_q;
  longint   axis_z_q;

  assign got = {out_rot_r2_c2, out_rot_r1_c2, out_rot_r0_c2,
                out_rot_r2_c1, out_rot_r1_c1, out_rot_r0_c1,
                out_rot_r2_c0, out_rot_r1_c0, out_rot_r0_c0};

  // Arctangent of 2^-i, Q30
  function automatic longint atan_step(input int i);
    longint r;
    case (i)
      0:       r = 64'h3243F6A8;
      1:       r = 64'h1DAC6705;
      2:       r = 64'h0FADBAFC;
      3:       r = 64'h07F56EA6;
      4:       r = 64'h03FEAB76;
      5:       r = 64'h01FFD55B;
      6:       r = 64'h00FFFAAA;
      7:       r = 64'h007FFF55;
      8:       r = 64'h003FFFEA;
      9:       r = 64'h001FFFFD;
      10:      r = 64'h000FFFFF;
      11:      r = 64'h0007FFFF;
      12:      r = 64'h0003FFFF;
      13:      r = 64'h0001FFFF;
      14:      r = 64'h0000FFFF;
      15:      r = 64'h00007FFF;
      16:      r = 64'h00003FFF;
      17:      r = 64'h00001FFF;
      18:      r = 64'h00000FFF;
      19:      r = 64'h000007FF;
      20:      r = 64'h000003FF;
      21:      r = 64'h000001FF;
      22:      r = 64'h000000FF;
      23:      r = 64'h0000007F;
      default: r = 0;
    endcase
    return r;
  endfunction

  // Bring a positive Q30 constant to the internal format, round half up
  function automatic longint q30_to_frac(input longint v);
    int sh;
    sh = 30 - FRAC_BITS;
    if (sh <= 0) begin
      return v;
    end
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // Round an exact entry sum to Q1.15 and clamp
  function automatic logic [OUT_W-1:0] round_entry(input longint acc);
    longint r;
    int     sh;
    sh = FRAC_BITS + 15;
    r = (acc + (longint'(1) << (sh - 1))) >>> sh;
    if (r > 32767) begin
      r = 32767;
    end
    if (r < -32768) begin
      r = -32768;
    end
    return r[OUT_W-1:0];
  endfunction

  // Rotation matrix about the axis for one angle
  function automatic rot_mat_t rodrigues_matrix(input logic signed [ANG_W-1:0] angle,
                                                input longint ax, input longint ay,
                                                input longint az);
    longint   z, x, y, dx, dy, step, c, s, t;
    longint   pi_f, half_pi_f, two_pi_f, one, cc, xs, ys, zs;
    bit       flip;
    rot_mat_t m;
    pi_f      = q30_to_frac(longint'(Q30_PI));
    half_pi_f = q30_to_frac(longint'(Q30_HALF_PI));
    two_pi_f  = q30_to_frac(longint'(Q30_TWO_PI));
    one       = longint'(1) << FRAC_BITS;
    flip      = 1'b0;

    // Rescale the angle to the internal format
    z = longint'(angle);
    if (FRAC_BITS >= ANG_FRAC) begin
      z = z <<< (FRAC_BITS - ANG_FRAC);
    end else begin
      z = z >>> (ANG_FRAC - FRAC_BITS);
    end

    // Wrap once by 2*pi, then fold by pi into the CORDIC range
    if (z > pi_f) begin
      z = z - two_pi_f;
    end else if (z < -pi_f) begin
      z = z + two_pi_f;
    end
    if (z > half_pi_f) begin
      z = z - pi_f;
      flip = 1'b1;
    end else if (z < -half_pi_f) begin
      z = z + pi_f;
      flip = 1'b1;
    end

    // Rotate the prescaled unit vector toward the angle
    x = q30_to_frac(longint'(Q30_GAIN));
    y = 0;
    for (int i = 0; i < CORDIC_STAGES && i < ATAN_LEN; i++) begin
      dx   = y >>> i;
      dy   = x >>> i;
      step = q30_to_frac(atan_step(i));
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = one - c;

    // Rodrigues terms, exact before the final rounding
    cc = c * (longint'(1) << 30);
    xs = s * ax * (longint'(1) << 15);
    ys = s * ay * (longint'(1) << 15);
    zs = s * az * (longint'(1) << 15);
    m[0] = round_entry(t * (ax * ax) + cc);
    m[1] = round_entry(t * (ax * ay) + zs);
    m[2] = round_entry(t * (ax * az) - ys);
    m[3] = round_entry(t * (ax * ay) - zs);
    m[4] = round_entry(t * (ay * ay) + cc);
    m[5] = round_entry(t * (ay * az) + xs);
    m[6] = round_entry(t * (ax * az) + ys);
    m[7] = round_entry(t * (ay * az) - xs);
    m[8] = round_entry(t * (az * az) + cc);
    return m;
  endfunction

  initial begin
    mismatch_count = 0;
    pending        = 0;
  end

  // Track the channels at each rising edge
  always @(posedge clk) begin : watch
    rot_mat_t want;
    if (!rst_n) begin
      axis_x_q = 0;
      axis_y_q = 0;
      axis_z_q = 0;
      expected_mats.delete();
      pending = 0;
    end else begin
      // Predict with the axis in force before this edge's write
      if (start && !busy) begin
        expected_mats.insert(expected_mats.size(),
                             rodrigues_matrix(in_angle, axis_x_q, axis_y_q, axis_z_q));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_AXIS_X: axis_x_q = longint'($signed(cfg_data));
          CFG_AXIS_Y: axis_y_q = longint'($signed(cfg_data));
          CFG_AXIS_Z: axis_z_q = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // Compare each strobed matrix with the oldest prediction
      if (out_strobe) begin
        if (expected_mats.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual r0c0 %0d",
                   $time, $signed(got[0]));
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_mats.pop_front();
          for (int k = 0; k < 9; k++) begin
            if (want[k] !== got[k]) begin
              $display("%0t ns: row %0d col %0d expected %0d actual %0d",
                       $time, k % 3, k / 3, $signed(want[k]), $signed(got[k]));
              mismatch_count = mismatch_count + 1;
            end
          end
        end
      end
      pending = expected_mats.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the rotation matrix testbench: clock, reset, axis writes and angle items.
// Depends on aarm_pkg, axis_angle_rotation_matrix_core and rot_matrix_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import aarm_pkg::*;

  localparam int          LATENCY      = 22;
  localparam int          QUIET_LIMIT  = 400;
  localparam int          NUM_PHASES   = 11;
  localparam int          PHASE_ITEMS  = 110;
  localparam int          NUM_CORNERS  = 20;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;   // unmapped index, must be ignored
  localparam int          PI_Q15       = 102944;
  localparam int          HALF_PI_Q15  = 51472;
  localparam int          TWO_PI_Q15   = 205887;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [ANG_W-1:0]  in_angle;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [1:0]               cfg_index;
  logic [AXIS_W-1:0]        cfg_data;
  logic                     out_strobe;
  logic signed [OUT_W-1:0]  out_rot_r0_c0, out_rot_r1_c0, out_rot_r2_c0;
  logic signed [OUT_W-1:0]  out_rot_r0_c1, out_rot_r1_c1, out_rot_r2_c1;
  logic signed [OUT_W-1:0]  out_rot_r0_c2, out_rot_r1_c2, out_rot_r2_c2;
  int                       mismatch_count;
  int                       pending;
  int                       quiet_cycles;
  int                       corner_angles [NUM_CORNERS];

  axis_angle_rotation_matrix_core uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_angle      (in_angle),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_strobe    (out_strobe),
    .out_rot_r0_c0 (out_rot_r0_c0),
    .out_rot_r1_c0 (out_rot_r1_c0),
    .out_rot_r2_c0 (out_rot_r2_c0),
    .out_rot_r0_c1 (out_rot_r0_c1),
    .out_rot_r1_c1 (out_rot_r1_c1),
    .out_rot_r2_c1 (out_rot_r2_c1),
    .out_rot_r0_c2 (out_rot_r0_c2),
    .out_rot_r1_c2 (out_rot_r1_c2),
    .out_rot_r2_c2 (out_rot_r2_c2)
  );

  rot_matrix_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_angle       (in_angle),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_rot_r0_c0  (out_rot_r0_c0),
    .out_rot_r1_c0  (out_rot_r1_c0),
    .out_rot_r2_c0  (out_rot_r2_c0),
    .out_rot_r0_c1  (out_rot_r0_c1),
    .out_rot_r1_c1  (out_rot_r1_c1),
    .out_rot_r2_c1  (out_rot_r2_c1),
    .out_rot_r0_c2  (out_rot_r0_c2),
    .out_rot_r1_c2  (out_rot_r1_c2),
    .out_rot_r2_c2  (out_rot_r2_c2),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // End the run when nothing moves on any channel for too long
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one angle item and hold it until taken
  task automatic send_angle(input logic signed [ANG_W-1:0] a);
    start    <= 1'b1;
    in_angle <= a;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Hold start low with junk on the angle port
  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) begin
      in_angle <= ANG_W'($urandom());
      @(negedge clk);
    end
  endtask

  // Write one register; valid stays up for a following write
  task automatic cfg_write(input logic [1:0] idx, input logic [AXIS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  // Hold off until every predicted matrix has come out
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
  endtask

  // Load the whole axis, plus a write to the unmapped index
  task automatic set_axis(input logic [AXIS_W-1:0] x, input logic [AXIS_W-1:0] y,
                          input logic [AXIS_W-1:0] z);
    cfg_write(CFG_AXIS_X, x);
    cfg_write(CFG_AXIS_Y, y);
    cfg_write(CFG_AXIS_Z, z);
    cfg_write(CFG_SPARE, AXIS_W'($urandom()));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly full-range angles, some near the wrap and fold points, some near zero
  function automatic logic signed [ANG_W-1:0] rand_angle();
    int sel;
    int v;
    int sgn;
    sel = $urandom_range(0, 9);
    sgn = $urandom_range(0, 1) ? -1 : 1;
    case (sel)
      0, 1, 2, 3, 4, 5: v = $urandom();
      6, 7:             v = sgn * (PI_Q15 + $urandom_range(0, 16) - 8);
      8:                v = sgn * (HALF_PI_Q15 + $urandom_range(0, 16) - 8);
      default:          v = sgn * $urandom_range(0, 64);
    endcase
    return ANG_W'(v);
  endfunction

  initial begin : stimulus
    real rx, ry, rz, norm;
    logic [AXIS_W-1:0] ax, ay, az;
    bit calm;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_angle  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AXIS_X;
    cfg_data  = '0;

    corner_angles = '{0, 262143, -262144, 1, -1, PI_Q15, PI_Q15 + 1, -PI_Q15,
                      -PI_Q15 - 1, HALF_PI_Q15, HALF_PI_Q15 + 1, HALF_PI_Q15 - 1,
                      -HALF_PI_Q15, -HALF_PI_Q15 - 1, TWO_PI_Q15, -TWO_PI_Q15,
                      32768, -32768, 245000, -245000};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Corner angles on the reset axis: diagonal is the cosine, rest is zero
    foreach (corner_angles[k]) begin
      send_angle(ANG_W'(corner_angles[k]));
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:  begin ax = 16'sd32767;  ay = 16'sd0;      az = 16'sd0;      end
        1:  begin ax = 16'sd0;      ay = 16'sd32767;  az = 16'sd0;      end
        2:  begin ax = 16'sd0;      ay = 16'sd0;      az = 16'sd32767;  end
        3:  begin ax = 16'sd32767;  ay = 16'sd32767;  az = 16'sd32767;  end
        4:  begin ax = -16'sd32768; ay = -16'sd32768; az = -16'sd32768; end
        5:  begin ax = 16'sd32767;  ay = -16'sd32768; az = 16'sd0;      end
        9:  begin
          ax = AXIS_W'($urandom());
          ay = AXIS_W'($urandom());
          az = AXIS_W'($urandom());
        end
        default: begin
          // Random direction scaled to unit length
          rx = $itor($signed(AXIS_W'($urandom())));
          ry = $itor($signed(AXIS_W'($urandom())));
          rz = $itor($signed(AXIS_W'($urandom())));
          norm = $sqrt(rx * rx + ry * ry + rz * rz);
          if (norm < 1.0) begin
            rx = 0.0;
            ry = 0.0;
            rz = 1.0;
            norm = 1.0;
          end
          ax = AXIS_W'($rtoi(rx / norm * 32767.0));
          ay = AXIS_W'($rtoi(ry / norm * 32767.0));
          az = AXIS_W'($rtoi(rz / norm * 32767.0));
        end
      endcase

      drain();
      set_axis(ax, ay, az);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Idle in bursts, with calm stretches and none in the last phase
        calm = (ph == NUM_PHASES - 1) || ((n / 20) % 3 == 2);
        if (!calm && $urandom_range(0, 5) == 0) begin
          idle_cycles($urandom_range(1, 15));
        end
        send_angle(rand_angle());
      end
    end

    // Let the pipeline empty, then allow time for any stray strobe
    drain();
    repeat (LATENCY + 8) @(negedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
